[hdl/ilst_pkg.sv]
package ilst_pkg;

	localparam logic [2:0] CMD_PUSH    = 3'd0;
	localparam logic [2:0] CMD_POP     = 3'd1;
	localparam logic [2:0] CMD_INS_AT  = 3'd2;
	localparam logic [2:0] CMD_REM_AT  = 3'd3;
	localparam logic [2:0] CMD_INS_MID = 3'd4;
	localparam logic [2:0] CMD_REM_MID = 3'd5;
	localparam logic [2:0] CMD_DUMP    = 3'd6;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef struct packed {
		logic edit;
		logic dump_start;
		logic dump_step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic dump_last;
	} dp_stat_t;

endpackage

[hdl/indexed_list_insert_remove_unit.sv]
// Edits (push, pop, insert, remove): result in the cycle after the accepting edge; a new
// command is taken every cycle while no dump is busy, since the whole register chain
// shifts at once. Dump of N entries: busy until the last entry is read, one result per
// cycle, the first after the dump state and the output registers; an empty dump gives
// a single result like an edit. Reset (arst_n low) empties the list and drops any dump
// in progress. Results leave on strobe for one cycle each; the receiver cannot stall.
module indexed_list_insert_remove_unit #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         command,
	input  logic [4:0]         position,
	input  logic signed [31:0] item_value,
	output logic               strobe,
	output logic [1:0]         status,
	output logic [4:0]         entry_count,
	output logic [3:0]         entry_index,
	output logic signed [31:0] entry_value,
	output logic               last
);

	ilst_pkg::ctrl_cmd_t cmd;
	ilst_pkg::dp_stat_t  stat;

	ilst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.busy    (busy),
		.cmd     (cmd)
	);

	ilst_dp #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.command     (command),
		.position    (position),
		.item_value  (item_value),
		.stat        (stat),
		.strobe      (strobe),
		.status      (status),
		.entry_count (entry_count),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.last        (last)
	);

endmodule

[hdl/ilst_ctrl.sv]
module ilst_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0]            command,
	input  ilst_pkg::dp_stat_t    stat,
	output logic                  busy,
	output ilst_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	state_t state_q;
	logic   accept;
	logic   is_dump;

	assign busy    = (state_q == ST_DUMP);
	assign accept  = start && !busy;
	assign is_dump = (command == ilst_pkg::CMD_DUMP) && !stat.count_zero;

	always_comb begin
		cmd.edit       = accept && !is_dump;
		cmd.dump_start = accept && is_dump;
		cmd.dump_step  = (state_q == ST_DUMP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.dump_start) begin
						state_q <= ST_DUMP;
					end
				end
				ST_DUMP: begin
					if (stat.dump_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/ilst_dp.sv]
module ilst_dp #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ilst_pkg::ctrl_cmd_t   cmd,
	input  logic [2:0]            command,
	input  logic [4:0]            position,
	input  logic signed [31:0]    item_value,
	output ilst_pkg::dp_stat_t    stat,
	output logic                  strobe,
	output logic [1:0]            status,
	output logic [4:0]            entry_count,
	output logic [3:0]            entry_index,
	output logic signed [31:0]    entry_value,
	output logic                  last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int PW = (CW > 5) ? CW : 5;

	logic signed [WIDTH-1:0] entries_q [DEPTH];
	logic signed [WIDTH-1:0] entries_d [DEPTH];
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           cnt_d;
	logic [IW-1:0]           idx_q;
	logic [1:0]              res_status;
	logic [PW-1:0]           sel_pos;
	logic [PW-1:0]           cnt_ext;
	logic signed [63:0]      item_ext;
	logic signed [WIDTH-1:0] item_word;

	logic                    strobe_q;
	logic [1:0]              status_q;
	logic [4:0]              count_q;
	logic [3:0]              index_q;
	logic signed [31:0]      value_q;
	logic                    last_q;

	assign item_ext  = 64'(item_value);
	assign item_word = item_ext[WIDTH-1:0];
	assign cnt_ext   = PW'(cnt_q);

	assign stat.count_zero = (cnt_q == '0);
	assign stat.dump_last  = (CW'(idx_q) == cnt_q - CW'(1));

	always_comb begin
		case (command)
			ilst_pkg::CMD_INS_AT,
			ilst_pkg::CMD_REM_AT:  sel_pos = PW'(position);
			ilst_pkg::CMD_INS_MID,
			ilst_pkg::CMD_REM_MID: sel_pos = PW'(cnt_q >> 1);
			default:               sel_pos = cnt_ext;
		endcase
	end

	always_comb begin
		entries_d  = entries_q;
		cnt_d      = cnt_q;
		res_status = ilst_pkg::STAT_OK;
		case (command)
			ilst_pkg::CMD_PUSH,
			ilst_pkg::CMD_INS_AT,
			ilst_pkg::CMD_INS_MID: begin
				if (sel_pos > cnt_ext) begin
					res_status = ilst_pkg::STAT_RANGE;
				end else if (cnt_q == CW'(DEPTH)) begin
					res_status = ilst_pkg::STAT_FULL;
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						if (PW'(i) == sel_pos) begin
							entries_d[i] = item_word;
						end else if (i > 0 && PW'(i) > sel_pos) begin
							entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
						end
					end
					cnt_d = cnt_q + CW'(1);
				end
			end
			ilst_pkg::CMD_POP: begin
				if (cnt_q == '0) begin
					res_status = ilst_pkg::STAT_EMPTY;
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
			end
			ilst_pkg::CMD_REM_AT,
			ilst_pkg::CMD_REM_MID: begin
				if (sel_pos >= cnt_ext) begin
					res_status = ilst_pkg::STAT_RANGE;
				end else begin
					for (int i = 0; i < DEPTH - 1; i++) begin
						if (PW'(i) >= sel_pos) begin
							entries_d[i] = entries_q[i + 1];
						end
					end
					cnt_d = cnt_q - CW'(1);
				end
			end
			ilst_pkg::CMD_DUMP: begin
				res_status = ilst_pkg::STAT_EMPTY;
			end
			default: begin
				res_status = ilst_pkg::STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.edit) begin
			entries_q <= entries_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.edit || cmd.dump_step;
			if (cmd.edit) begin
				cnt_q <= cnt_d;
			end
			if (cmd.dump_start) begin
				idx_q <= '0;
			end else if (cmd.dump_step) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.edit) begin
			status_q <= res_status;
			count_q  <= 5'(cnt_d);
			index_q  <= '0;
			value_q  <= '0;
			last_q   <= 1'b1;
		end else if (cmd.dump_step) begin
			status_q <= ilst_pkg::STAT_OK;
			count_q  <= 5'(cnt_q);
			index_q  <= 4'(idx_q);
			value_q  <= 32'(entries_q[idx_q]);
			last_q   <= stat.dump_last;
		end
	end

	assign strobe      = strobe_q;
	assign status      = status_q;
	assign entry_count = count_q;
	assign entry_index = index_q;
	assign entry_value = value_q;
	assign last        = last_q;

endmodule

[sim/indexed_list_insert_remove_unit_test.sv]
module indexed_list_insert_remove_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int RANDOM_ITEMS = 182;
	localparam int CALM_TAIL = 40;
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	typedef struct packed {
		logic [1:0]  stat;
		logic [4:0]  cnt;
		logic [3:0]  idx;
		logic [31:0] word;
		logic        fin;
	} list_result_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [4:0]  pos;
		logic [31:0] word;
		logic [4:0]  times;
		logic        typed;
		logic [1:0]  stat;
		logic [4:0]  cnt;
	} list_step_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         command = ilst_pkg::CMD_PUSH;
	logic [4:0]         position = '0;
	logic signed [31:0] item_value = '0;
	logic               strobe;
	logic [1:0]         status;
	logic [4:0]         entry_count;
	logic [3:0]         entry_index;
	logic signed [31:0] entry_value;
	logic               last;

	logic [31:0]  shadow_words [DEPTH];
	int unsigned  shadow_len = 0;
	list_result_t pending_results [$];
	list_step_t   plan [$];
	int           mismatches = 0;
	int           quiet_cycles = 0;

	indexed_list_insert_remove_unit #(
		.DEPTH(DEPTH),
		.WIDTH(32)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.position(position),
		.item_value(item_value),
		.strobe(strobe),
		.status(status),
		.entry_count(entry_count),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("%0t %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	task automatic queue_result(input list_result_t res);
		pending_results = {pending_results, res};
	endtask

	task automatic drop_newest();
		pending_results.delete(pending_results.size() - 1);
	endtask

	function automatic logic [1:0] insert_word(input int unsigned at, input logic [31:0] word);
		int unsigned i;
		if (at > shadow_len) return ilst_pkg::STAT_RANGE;
		if (shadow_len >= DEPTH) return ilst_pkg::STAT_FULL;
		for (i = shadow_len; i > at; i--) shadow_words[i] = shadow_words[i - 1];
		shadow_words[at] = word;
		shadow_len++;
		return ilst_pkg::STAT_OK;
	endfunction

	function automatic logic [1:0] remove_word(input int unsigned at);
		int unsigned i;
		if (at >= shadow_len) return ilst_pkg::STAT_RANGE;
		for (i = at; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i + 1];
		shadow_len--;
		return ilst_pkg::STAT_OK;
	endfunction

	task automatic predict_list_command(input logic [2:0] cmd, input logic [4:0] pos,
			input logic [31:0] word);
		logic [1:0]  stat;
		int unsigned i;
		stat = ilst_pkg::STAT_OK;
		case (cmd)
			ilst_pkg::CMD_PUSH: stat = insert_word(shadow_len, word);
			ilst_pkg::CMD_POP: begin
				if (shadow_len == 0) stat = ilst_pkg::STAT_EMPTY;
				else shadow_len--;
			end
			ilst_pkg::CMD_INS_AT: stat = insert_word(pos, word);
			ilst_pkg::CMD_REM_AT: stat = remove_word(pos);
			ilst_pkg::CMD_INS_MID: stat = insert_word(shadow_len / 2, word);
			ilst_pkg::CMD_REM_MID: stat = remove_word(shadow_len / 2);
			ilst_pkg::CMD_DUMP: begin
				if (shadow_len == 0) begin
					queue_result('{ilst_pkg::STAT_EMPTY, 5'd0, 4'd0, 32'd0, 1'b1});
				end else begin
					for (i = 0; i < shadow_len; i++) begin
						queue_result('{ilst_pkg::STAT_OK, 5'(shadow_len), 4'(i),
							shadow_words[i], i + 1 == shadow_len});
					end
				end
				return;
			end
			default: ;
		endcase
		queue_result('{stat, 5'(shadow_len), 4'd0, 32'd0, 1'b1});
	endtask

	// hold the transaction until taken; typed expectations replace the prediction
	task automatic issue(input logic [2:0] cmd, input logic [4:0] pos, input logic [31:0] word,
			input logic typed, input logic [1:0] stat, input logic [4:0] cnt);
		int depth_before;
		start <= 1'b1;
		command <= cmd;
		position <= pos;
		item_value <= word;
		@(posedge clk);
		while (busy) @(posedge clk);
		depth_before = pending_results.size();
		predict_list_command(cmd, pos, word);
		if (typed) begin
			while (pending_results.size() > depth_before) drop_newest();
			queue_result('{stat, cnt, 4'd0, 32'd0, 1'b1});
		end
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 32'(status), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.stat) report_mismatch("status", 32'(status), 32'(want.stat));
				if (entry_count !== want.cnt) begin
					report_mismatch("entry_count", 32'(entry_count), 32'(want.cnt));
				end
				if (entry_index !== want.idx) begin
					report_mismatch("entry_index", 32'(entry_index), 32'(want.idx));
				end
				if (entry_value !== want.word) report_mismatch("entry_value", entry_value, want.word);
				if (last !== want.fin) report_mismatch("last", 32'(last), 32'(want.fin));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		list_step_t  row;
		logic [2:0]  cmd;
		logic [4:0]  pos;
		logic [31:0] word;
		int          n;
		int          k;
		int          r;
		int          grow_mode;
		int          grow_odds;
		bit          gaps_on;
		bit          grow;

		plan = '{
			'{ilst_pkg::CMD_POP,     5'd0,  32'd0,         5'd1,  1'b1, ilst_pkg::STAT_EMPTY, 5'd0},
			'{ilst_pkg::CMD_DUMP,    5'd0,  32'd0,         5'd1,  1'b1, ilst_pkg::STAT_EMPTY, 5'd0},
			'{ilst_pkg::CMD_REM_MID, 5'd0,  32'd0,         5'd1,  1'b1, ilst_pkg::STAT_RANGE, 5'd0},
			'{ilst_pkg::CMD_REM_AT,  5'd0,  32'd0,         5'd1,  1'b1, ilst_pkg::STAT_RANGE, 5'd0},
			'{ilst_pkg::CMD_INS_AT,  5'd1,  32'd5,         5'd1,  1'b1, ilst_pkg::STAT_RANGE, 5'd0},
			'{ilst_pkg::CMD_PUSH,    5'd0,  32'h7FFF_FFFF, 5'd1,  1'b1, ilst_pkg::STAT_OK,    5'd1},
			'{ilst_pkg::CMD_PUSH,    5'd31, 32'h8000_0000, 5'd1,  1'b1, ilst_pkg::STAT_OK,    5'd2},
			'{ilst_pkg::CMD_INS_AT,  5'd0,  32'd0,         5'd1,  1'b1, ilst_pkg::STAT_OK,    5'd3},
			'{ilst_pkg::CMD_INS_AT,  5'd3,  32'hFFFF_FFFF, 5'd1,  1'b1, ilst_pkg::STAT_OK,    5'd4},
			'{ilst_pkg::CMD_INS_MID, 5'd0,  32'd1,         5'd1,  1'b1, ilst_pkg::STAT_OK,    5'd5},
			'{ilst_pkg::CMD_DUMP,    5'd0,  32'd0,         5'd1,  1'b0, ilst_pkg::STAT_OK,    5'd0},
			'{ilst_pkg::CMD_REM_AT,  5'd5,  32'd0,         5'd1,  1'b1, ilst_pkg::STAT_RANGE, 5'd5},
			'{ilst_pkg::CMD_INS_AT,  5'd31, 32'd9,         5'd1,  1'b1, ilst_pkg::STAT_RANGE, 5'd5},
			'{CMD_UNUSED,            5'd0,  32'd0,         5'd1,  1'b1, ilst_pkg::STAT_OK,    5'd5},
			'{ilst_pkg::CMD_REM_MID, 5'd0,  32'd0,         5'd1,  1'b0, ilst_pkg::STAT_OK,    5'd0},
			'{ilst_pkg::CMD_POP,     5'd0,  32'd0,         5'd1,  1'b0, ilst_pkg::STAT_OK,    5'd0},
			'{ilst_pkg::CMD_REM_AT,  5'd0,  32'd0,         5'd1,  1'b0, ilst_pkg::STAT_OK,    5'd0},
			'{ilst_pkg::CMD_PUSH,    5'd0,  32'h1234_5678, 5'd14, 1'b0, ilst_pkg::STAT_OK,    5'd0},
			'{ilst_pkg::CMD_INS_AT,  5'd16, 32'hAAAA_5555, 5'd1,  1'b1, ilst_pkg::STAT_FULL,  5'd16},
			'{ilst_pkg::CMD_INS_AT,  5'd17, 32'h5555_AAAA, 5'd1,  1'b1, ilst_pkg::STAT_RANGE, 5'd16},
			'{ilst_pkg::CMD_INS_MID, 5'd0,  32'd3,         5'd1,  1'b1, ilst_pkg::STAT_FULL,  5'd16},
			'{ilst_pkg::CMD_PUSH,    5'd0,  32'd4,         5'd1,  1'b1, ilst_pkg::STAT_FULL,  5'd16},
			'{ilst_pkg::CMD_DUMP,    5'd0,  32'd0,         5'd1,  1'b0, ilst_pkg::STAT_OK,    5'd0},
			'{ilst_pkg::CMD_REM_AT,  5'd15, 32'd0,         5'd1,  1'b0, ilst_pkg::STAT_OK,    5'd0},
			'{ilst_pkg::CMD_DUMP,    5'd0,  32'd0,         5'd1,  1'b0, ilst_pkg::STAT_OK,    5'd0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			for (k = 0; k < row.times; k++) begin
				issue(row.cmd, row.pos, row.word + 32'(k), row.typed, row.stat, row.cnt);
			end
		end

		grow_mode = 0;
		gaps_on = 1'b0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 30 == 0) grow_mode = $urandom_range(2);
			if (n % 16 == 0) gaps_on = (n < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(1) == 1);
			if (gaps_on && $urandom_range(9) < 4) hold_off($urandom_range(12, 1));

			r = $urandom_range(99);
			if (r < 10) begin
				cmd = ilst_pkg::CMD_DUMP;
			end else if (r < 12) begin
				cmd = CMD_UNUSED;
			end else begin
				grow_odds = (grow_mode == 0) ? 75 : (grow_mode == 1) ? 25 : 50;
				grow = $urandom_range(99) < grow_odds;
				r = $urandom_range(2);
				if (grow) begin
					cmd = (r == 0) ? ilst_pkg::CMD_PUSH :
						(r == 1) ? ilst_pkg::CMD_INS_AT : ilst_pkg::CMD_INS_MID;
				end else begin
					cmd = (r == 0) ? ilst_pkg::CMD_POP :
						(r == 1) ? ilst_pkg::CMD_REM_AT : ilst_pkg::CMD_REM_MID;
				end
			end

			if ($urandom_range(9) == 0) pos = 5'($urandom);
			else if (cmd == ilst_pkg::CMD_REM_AT && shadow_len > 0) begin
				pos = 5'($urandom_range(shadow_len - 1));
			end else pos = 5'($urandom_range(shadow_len));

			r = $urandom_range(9);
			case (r)
				0: word = 32'h8000_0000;
				1: word = 32'h7FFF_FFFF;
				2: word = 32'hFFFF_FFFF;
				3: word = 32'h0000_0000;
				default: word = $urandom;
			endcase

			issue(cmd, pos, word, 1'b0, ilst_pkg::STAT_OK, 5'd0);
		end
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
